@@ hdl/idp_pkg.sv @@
`default_nettype none

package idp_pkg;

    // Depth of the queue between the front end and the back end.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Fixed-point format of the scales and the bias.
    localparam int Q_SHIFT = 16;

    // Rounding offsets, added to the magnitude: to nearest, ties toward positive infinity.
    localparam logic [63:0] RND_POS = 64'd32768;
    localparam logic [63:0] RND_NEG = 64'd32767;

    localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] OUT_MIN = 48'h8000_0000_0000;

    // One classified term as it travels through the queue.
    typedef struct packed {
        logic [15:0] prod;
        logic        last;
        logic [31:0] row_scale;
        logic [31:0] col_scale;
        logic [31:0] bias;
    } item_t;

endpackage

`default_nettype wire

@@ hdl/idp_front.sv @@
`default_nettype none

module idp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_data,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     a_val,
    input  wire logic [7:0]     b_val,
    input  wire logic [31:0]    row_scale,
    input  wire logic [31:0]    col_scale,
    input  wire logic [31:0]    bias_value,
    input  wire logic           last,
    output logic                push_valid,
    input  wire logic           push_ready,
    output idp_pkg::item_t      push_item
);
    import idp_pkg::*;

    logic bias_en_reg;
    logic bias_en_next;

    assign cfg_ready    = 1'b1;
    assign bias_en_next = (cfg_valid && cfg_ready) ? cfg_data : bias_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_en_reg <= 1'b0;
        end
        else
        begin
            bias_en_reg <= bias_en_next;
        end
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    // The int8 product is formed here so the back end only has to add it.
    // The bias is resolved against the enable now; the register is to change only while idle (not enforced here).
    always_comb
    begin
        push_item.prod      = 16'($signed(a_val) * $signed(b_val));
        push_item.last      = last;
        push_item.row_scale = row_scale;
        push_item.col_scale = col_scale;
        push_item.bias      = bias_en_reg ? bias_value : 32'd0;
    end

endmodule

`default_nettype wire

@@ hdl/idp_fifo.sv @@
`default_nettype none

module idp_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire idp_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output idp_pkg::item_t      pop_item
);
    import idp_pkg::*;

    item_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/idp_back.sv @@
`default_nettype none

module idp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire idp_pkg::item_t pop_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [47:0]         result,
    output logic [31:0]         raw_sum,
    output logic                saturated
);
    import idp_pkg::*;

    localparam logic [2:0] SQ_IDLE = 3'd0;
    localparam logic [2:0] SQ_M1   = 3'd1;
    localparam logic [2:0] SQ_R1   = 3'd2;
    localparam logic [2:0] SQ_M2   = 3'd3;
    localparam logic [2:0] SQ_M3   = 3'd4;
    localparam logic [2:0] SQ_R2   = 3'd5;
    localparam logic [2:0] SQ_FIN  = 3'd6;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic [31:0] sum_mag_reg;
    logic [31:0] sum_mag_next;
    logic [31:0] rs_mag_reg;
    logic [31:0] rs_mag_next;
    logic [31:0] cs_mag_reg;
    logic [31:0] cs_mag_next;
    logic        cs_neg_reg;
    logic        cs_neg_next;
    logic        neg1_reg;
    logic        neg1_next;
    logic        neg2_reg;
    logic        neg2_next;
    logic [31:0] bias_reg;
    logic [31:0] bias_next;
    logic [63:0] mul_reg;
    logic [63:0] mul_next;
    logic [46:0] t1_reg;
    logic [46:0] t1_next;
    logic [63:0] lo_reg;
    logic [63:0] lo_next;
    logic [63:0] r_reg;
    logic [63:0] r_next;
    logic [47:0] result_reg;
    logic [47:0] result_next;
    logic [31:0] raw_sum_reg;
    logic [31:0] raw_sum_next;
    logic        sat_reg;
    logic        sat_next;

    logic        take;
    logic [31:0] sum_now;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_out;
    logic [63:0] rnd_sum;
    logic [63:0] lo_rnd;
    logic [63:0] res_full;
    logic        res_ovf;

    // A closing term waits in the queue until the scaling sequencer is free;
    // ordinary terms keep accumulating while a previous result is being scaled.
    assign pop_ready = !pop_item.last || (state_reg == SQ_IDLE);
    assign take      = pop_valid && pop_ready;
    assign sum_now   = acc_reg + {{16{pop_item.prod[15]}}, pop_item.prod};

    // One shared 32 x 32 unsigned multiplier serves all three partial products.
    always_comb
    begin
        unique case (state_reg)
            SQ_M1:
            begin
                mul_a = sum_mag_reg;
                mul_b = rs_mag_reg;
            end
            SQ_M2:
            begin
                mul_a = t1_reg[31:0];
                mul_b = cs_mag_reg;
            end
            default:
            begin
                mul_a = {17'd0, t1_reg[46:32]};
                mul_b = cs_mag_reg;
            end
        endcase
    end

    assign mul_out  = mul_a * mul_b;
    assign rnd_sum  = mul_reg + (neg1_reg ? RND_NEG : RND_POS);
    assign lo_rnd   = lo_reg + (neg2_reg ? RND_NEG : RND_POS);
    // Conditional negation folded into the bias add: -r = ~r + 1.
    assign res_full = (neg2_reg ? ~r_reg : r_reg) + {{32{bias_reg[31]}}, bias_reg}
                      + {63'd0, neg2_reg};
    assign res_ovf  = !((res_full[63:47] == '0) || (res_full[63:47] == '1));

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        sum_next       = sum_reg;
        sum_mag_next   = sum_mag_reg;
        rs_mag_next    = rs_mag_reg;
        cs_mag_next    = cs_mag_reg;
        cs_neg_next    = cs_neg_reg;
        neg1_next      = neg1_reg;
        neg2_next      = neg2_reg;
        bias_next      = bias_reg;
        mul_next       = mul_reg;
        t1_next        = t1_reg;
        lo_next        = lo_reg;
        r_next         = r_reg;
        result_next    = result_reg;
        raw_sum_next   = raw_sum_reg;
        sat_next       = sat_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            if (pop_item.last)
            begin
                acc_next     = '0;
                sum_next     = sum_now;
                sum_mag_next = sum_now[31] ? (~sum_now + 1'b1) : sum_now;
                rs_mag_next  = pop_item.row_scale[31] ? (~pop_item.row_scale + 1'b1)
                                                      : pop_item.row_scale;
                cs_mag_next  = pop_item.col_scale[31] ? (~pop_item.col_scale + 1'b1)
                                                      : pop_item.col_scale;
                cs_neg_next  = pop_item.col_scale[31];
                neg1_next    = sum_now[31] ^ pop_item.row_scale[31];
                bias_next    = pop_item.bias;
                state_next   = SQ_M1;
            end
            else
            begin
                acc_next = sum_now;
            end
        end

        unique case (state_reg)
            SQ_IDLE:
            begin
            end
            SQ_M1:
            begin
                mul_next   = mul_out;
                state_next = SQ_R1;
            end
            SQ_R1:
            begin
                t1_next    = rnd_sum[62:Q_SHIFT];
                // The first scaled value is negative only if it is not zero.
                neg2_next  = (neg1_reg && (rnd_sum[62:Q_SHIFT] != '0)) ^ cs_neg_reg;
                state_next = SQ_M2;
            end
            SQ_M2:
            begin
                lo_next    = mul_out;
                state_next = SQ_M3;
            end
            SQ_M3:
            begin
                mul_next   = mul_out;
                lo_next    = lo_rnd >> Q_SHIFT;
                state_next = SQ_R2;
            end
            SQ_R2:
            begin
                r_next     = (mul_reg << Q_SHIFT) + lo_reg;
                state_next = SQ_FIN;
            end
            SQ_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    raw_sum_next   = sum_reg;
                    sat_next       = res_ovf;
                    if (res_ovf)
                    begin
                        result_next = res_full[63] ? OUT_MIN : OUT_MAX;
                    end
                    else
                    begin
                        result_next = res_full[47:0];
                    end
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        sum_mag_reg <= sum_mag_next;
        rs_mag_reg  <= rs_mag_next;
        cs_mag_reg  <= cs_mag_next;
        cs_neg_reg  <= cs_neg_next;
        neg1_reg    <= neg1_next;
        neg2_reg    <= neg2_next;
        bias_reg    <= bias_next;
        mul_reg     <= mul_next;
        t1_reg      <= t1_next;
        lo_reg      <= lo_next;
        r_reg       <= r_next;
        result_reg  <= result_next;
        raw_sum_reg <= raw_sum_next;
        sat_reg     <= sat_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign raw_sum   = raw_sum_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

@@ hdl/int8_dot_product_dequant.sv @@
`default_nettype none

// Int8 dot product with Q15.16 dequantization. Each transfer on the input
// channel adds one signed int8 product into a 32-bit accumulator that wraps;
// the transfer flagged last closes the run and yields one result: the sum
// scaled by row_scale and then col_scale (each rounded to nearest and shifted
// right 16), plus bias_value when bias_enable is set, saturated to Q31.16.
// Ordinary terms are taken at one per cycle while the four-entry queue has room. A
// closing term hands its sum to a scaling sequencer built around one shared
// 32 x 32 multiplier, which steps through SQ_M1, SQ_R1, SQ_M2, SQ_M3, SQ_R2 and
// SQ_FIN per result; the next run keeps accumulating meanwhile, but its closing
// term is not taken until the sequencer is back in SQ_IDLE, so short runs are
// paced by that sequencer. A result is held in an output register until taken;
// a result that is not taken holds the sequencer. Write bias_enable only while
// no run is in progress.
module int8_dot_product_dequant (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_data,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     a_val,
    input  wire logic [7:0]     b_val,
    input  wire logic [31:0]    row_scale,
    input  wire logic [31:0]    col_scale,
    input  wire logic [31:0]    bias_value,
    input  wire logic           last,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [47:0]         result,
    output logic [31:0]         raw_sum,
    output logic                saturated
);
    import idp_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    idp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .a_val      (a_val),
        .b_val      (b_val),
        .row_scale  (row_scale),
        .col_scale  (col_scale),
        .bias_value (bias_value),
        .last       (last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    idp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    idp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result),
        .raw_sum    (raw_sum),
        .saturated  (saturated)
    );

endmodule

`default_nettype wire
